// ===== rtl/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, register indexes, constants and the CORDIC angle table of the
// frequency response block.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int POLY_ORDER   = 2;
  localparam int CORDIC_STEPS = 28;
  localparam int LOG_STEPS    = 30;
  localparam int FIFO_DEPTH   = 4;

  // degrees in Q16.16 and Q.24
  localparam logic signed [25:0] DEG180    = 26'sd11796480;
  localparam logic signed [25:0] DEG360    = 26'sd23592960;
  localparam logic signed [32:0] DEG360_W  = 33'sd23592960;
  localparam logic signed [32:0] DEG90_Q24 = 33'sd1509949440;
  // 10 log10(2) in Q.22
  localparam logic [23:0] GAIN_K = 24'd12626113;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_NUM_S2 = 3'd0,
    REG_NUM_S1 = 3'd1,
    REG_NUM_S0 = 3'd2,
    REG_DEN_S2 = 3'd3,
    REG_DEN_S1 = 3'd4,
    REG_DEN_S0 = 3'd5
  } reg_idx_t;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DEN_ZERO  = 2'd1;
  localparam logic [1:0] ST_NUM_ZERO  = 2'd2;
  localparam logic [1:0] ST_BOTH_ZERO = 2'd3;

  typedef struct packed {
    logic [31:0] omega;
    logic        sweep_start;
  } item_t;

  typedef struct packed {
    logic signed [31:0] gain_db;
    logic signed [31:0] phase_unwrapped;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic signed [31:0] s2;
    logic signed [31:0] s1;
    logic signed [31:0] s0;
  } poly_t;

  typedef struct packed {
    poly_t num;
    poly_t den;
  } coefs_t;

  // queue entry: frequency with its square already formed
  typedef struct packed {
    logic [31:0] omega;
    logic [63:0] omega_sq;
    logic        sweep_start;
  } point_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [30:0] atan_deg(input logic [4:0] i);
    logic [30:0] a;
    case (i)
      5'd0:  a = 31'd754974720;
      5'd1:  a = 31'd445687602;
      5'd2:  a = 31'd235489088;
      5'd3:  a = 31'd119537938;
      5'd4:  a = 31'd60000934;
      5'd5:  a = 31'd30029717;
      5'd6:  a = 31'd15018523;
      5'd7:  a = 31'd7509720;
      5'd8:  a = 31'd3754917;
      5'd9:  a = 31'd1877466;
      5'd10: a = 31'd938734;
      5'd11: a = 31'd469367;
      5'd12: a = 31'd234684;
      5'd13: a = 31'd117342;
      5'd14: a = 31'd58671;
      5'd15: a = 31'd29335;
      5'd16: a = 31'd14668;
      5'd17: a = 31'd7334;
      5'd18: a = 31'd3667;
      5'd19: a = 31'd1833;
      5'd20: a = 31'd917;
      5'd21: a = 31'd458;
      5'd22: a = 31'd229;
      5'd23: a = 31'd115;
      5'd24: a = 31'd57;
      5'd25: a = 31'd29;
      5'd26: a = 31'd14;
      5'd27: a = 31'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/bode_frequency_response.sv =====
// ----------------------------------------------------------------------------
// bode_frequency_response
// Gain in dB and unwrapped phase in degrees of N(s)/D(s) at s = jw.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): one angular frequency per
//   transaction with a sweep_start flag that clears the unwrap offset.
//   result channel (result_valid/result_ready/result): gain_db,
//   phase_unwrapped and status, one result per item, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): coefficient
//   writes, always ready; write only while no item is in flight.
// One item is worked at a time. Each nonzero polynomial runs the 30 log2
// squaring steps on the shared 32x32 multiplier (CORDIC runs beside them)
// after the normalizing shifts and the leading-one shifts; a zero one skips
// them. A four-entry queue takes further items while one is evaluated.
// Reset restores the default coefficients, empties the queue and clears the
// unwrap history. When the receiver stalls, the result register holds, the
// sequencer waits at its last step and the queue fills before item_ready
// drops.
// ----------------------------------------------------------------------------
module bode_frequency_response import bfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  coefs_t coefs;
  logic   push;
  point_t push_data;
  logic   pop;
  point_t pop_data;
  logic   q_full;
  logic   q_empty;

  bfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coefs      (coefs),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  bfr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .coefs        (coefs),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/bfr_front.sv =====
// ----------------------------------------------------------------------------
// bfr_front
// Takes input transactions and configuration writes, holds the coefficient
// registers and squares each frequency before it enters the point queue.
// ----------------------------------------------------------------------------
module bfr_front import bfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output coefs_t      coefs,
  output logic        push,
  output point_t      push_data,
  input  logic        q_full
);

  logic  stg_valid;
  item_t stg;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.num.s2 <= 32'sd0;
      coefs.num.s1 <= 32'sd655360;
      coefs.num.s0 <= 32'sd655360;
      coefs.den.s2 <= 32'sd6554;
      coefs.den.s1 <= 32'sd65536;
      coefs.den.s0 <= 32'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_S2: coefs.num.s2 <= cfg_data;
        REG_NUM_S1: coefs.num.s1 <= cfg_data;
        REG_NUM_S0: coefs.num.s0 <= cfg_data;
        REG_DEN_S2: coefs.den.s2 <= cfg_data;
        REG_DEN_S1: coefs.den.s1 <= cfg_data;
        REG_DEN_S0: coefs.den.s0 <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the input stage into the queue when there is room
  assign push       = stg_valid && !q_full;
  assign item_ready = !stg_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (item_ready) begin
      stg_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stg <= item;
    end
  end

  // square the frequency; the queue entry registers the product
  always_comb begin
    push_data.omega       = stg.omega;
    push_data.omega_sq    = 64'(stg.omega) * 64'(stg.omega);
    push_data.sweep_start = stg.sweep_start;
  end

endmodule

// ===== rtl/bfr_fifo.sv =====
// ----------------------------------------------------------------------------
// bfr_fifo
// Short point queue between the front and the evaluation sequencer.
// ----------------------------------------------------------------------------
module bfr_fifo import bfr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  point_t push_data,
  input  logic   pop,
  output point_t pop_data,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  point_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // store an entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/bfr_back.sv =====
// ----------------------------------------------------------------------------
// bfr_back
// Evaluation sequencer: forms N(jw) and D(jw) on a shared 32x32 multiplier,
// normalizes them, runs log2 squaring and CORDIC side by side, then forms
// gain, phase, unwrapping and the result register.
// ----------------------------------------------------------------------------
module bfr_back import bfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  coefs_t  coefs,
  input  logic    q_empty,
  input  point_t  q_data,
  output logic    q_pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_MUL_A = 16'h0002,
    S_MUL_B = 16'h0004,
    S_MUL_C = 16'h0008,
    S_RESUM = 16'h0010,
    S_REABS = 16'h0020,
    S_NORM  = 16'h0040,
    S_SQX   = 16'h0080,
    S_SQY   = 16'h0100,
    S_SQS   = 16'h0200,
    S_LNORM = 16'h0400,
    S_ITER  = 16'h0800,
    S_POST  = 16'h1000,
    S_GAIN  = 16'h2000,
    S_GMUL  = 16'h4000,
    S_GRND  = 16'h8000
  } state_t;

  state_t state;

  logic        den_sel;
  logic [4:0]  it;
  logic [6:0]  k;
  logic [5:0]  e;
  logic [31:0] omega;
  logic [63:0] omega_sq;
  logic        start_r;

  logic [63:0]        mp;
  logic [31:0]        t2lo;
  logic [95:0]        t2;
  logic signed [96:0] re_s;
  logic [95:0]        re_m;
  logic [79:0]        im;
  logic               s_re;
  logic               s_im;
  logic               zflag;
  logic [59:0]        msq;
  logic [60:0]        mm;
  logic [30:0]        v;
  logic [29:0]        frac;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [32:0] z;

  logic [38:0]        ln;
  logic [38:0]        ld;
  logic signed [24:0] an;
  logic signed [24:0] ad;
  logic               nz;
  logic               dz;
  logic [38:0]        diff;
  logic               gneg;
  logic [62:0]        gp;
  logic signed [24:0] raw;
  logic signed [24:0] prev_raw;
  logic signed [31:0] offset;
  logic               have_prev;

  // combinational helpers
  poly_t              pc;
  logic signed [31:0] c2;
  logic [31:0]        c2m;
  logic [31:0]        c1m;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic signed [96:0] c0x;
  logic signed [96:0] t2x;
  logic [95:0]        or_w;
  logic [31:0]        sq;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] atan_z;
  logic signed [32:0] zc;
  logic [31:0]        a_sum;
  logic signed [24:0] a25;
  logic signed [24:0] ang;
  logic               xneg;
  logic               yneg;
  logic [38:0]        lval;
  logic signed [25:0] rawd;
  logic signed [25:0] rawd_w;
  logic signed [25:0] dphase;
  logic signed [32:0] cand;
  logic [62:0]        gsum;
  logic [26:0]        gr;
  logic signed [31:0] gain_v;
  logic signed [32:0] psum;
  logic signed [31:0] phase_v;
  logic [1:0]         status_v;
  logic               res_load;

  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] val,
                                                input logic [4:0] sh);
    logic [33:0] m;
    m = val[33] ? 34'(-val) : 34'(val);
    m = m >> sh;
    return val[33] ? -$signed(m) : $signed(m);
  endfunction

  // select coefficients of the polynomial in work
  always_comb begin
    pc  = den_sel ? coefs.den : coefs.num;
    c2  = (POLY_ORDER >= 2) ? pc.s2 : 32'sd0;
    c2m = c2[31] ? (~c2 + 32'd1) : c2;
    c1m = pc.s1[31] ? (~pc.s1 + 32'd1) : pc.s1;
  end

  // shared multiplier operands
  always_comb begin
    unique case (state)
      S_MUL_A: begin mul_a = c2m;               mul_b = omega_sq[31:0];  end
      S_MUL_B: begin mul_a = c2m;               mul_b = omega_sq[63:32]; end
      S_MUL_C: begin mul_a = c1m;               mul_b = omega;           end
      S_SQX:   begin mul_a = {2'b00, re_m[29:0]}; mul_b = {2'b00, re_m[29:0]}; end
      S_SQY:   begin mul_a = {2'b00, im[29:0]};   mul_b = {2'b00, im[29:0]};   end
      S_ITER:  begin mul_a = {1'b0, v};         mul_b = {1'b0, v};       end
      default: begin mul_a = '0;                mul_b = '0;              end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // real part and normalization helpers
  always_comb begin
    c0x  = $signed({{33{pc.s0[31]}}, pc.s0, 32'b0});
    t2x  = $signed({1'b0, t2});
    or_w = re_m | {16'b0, im};
    sq   = mul_p[61:30];
  end

  // CORDIC step
  always_comb begin
    dx     = shr_tz(cy, it);
    dy     = shr_tz(cx, it);
    atan_z = $signed({2'b00, atan_deg(it)});
  end

  // angle and log of the finished polynomial
  always_comb begin
    if (z < 0)              zc = '0;
    else if (z > DEG90_Q24) zc = DEG90_Q24;
    else                    zc = z;
    a_sum = 32'(zc) + 32'd128;
    a25   = $signed({2'b00, a_sum[30:8]});
    xneg  = s_re && (re_m[29:0] != '0);
    yneg  = s_im && (im[29:0] != '0);
    if (xneg) ang = yneg ? (a25 - 25'(DEG180)) : (25'(DEG180) - a25);
    else      ang = yneg ? -a25 : a25;
    lval = 39'({k, 31'b0}) + 39'({e, frac});
  end

  // raw phase, unwrap candidate, gain rounding and saturation
  always_comb begin
    rawd = {an[24], an} - {ad[24], ad};
    if (rawd > DEG180)        rawd_w = rawd - DEG360;
    else if (rawd <= -DEG180) rawd_w = rawd + DEG360;
    else                      rawd_w = rawd;

    dphase = {raw[24], raw} - {prev_raw[24], prev_raw};
    if (dphase > DEG180)       cand = {offset[31], offset} - DEG360_W;
    else if (dphase < -DEG180) cand = {offset[31], offset} + DEG360_W;
    else                       cand = {offset[31], offset};

    gsum     = gp + (63'd1 << 35);
    gr       = gsum[62:36];
    status_v = {nz, dz};
    case (status_v)
      ST_DEN_ZERO:  gain_v = 32'sh7fffffff;
      ST_NUM_ZERO:  gain_v = 32'sh80000000;
      ST_BOTH_ZERO: gain_v = 32'sd0;
      default:      gain_v = gneg ? -$signed(32'(gr)) : $signed(32'(gr));
    endcase

    psum = {{8{raw[24]}}, raw} + {offset[31], offset};
    if (psum[32] != psum[31]) phase_v = psum[32] ? 32'sh80000000 : 32'sh7fffffff;
    else                      phase_v = psum[31:0];
  end

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign res_load = (state == S_GRND) && (!result_valid || result_ready);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      den_sel   <= 1'b0;
      it        <= '0;
      k         <= '0;
      e         <= '0;
      offset    <= '0;
      prev_raw  <= '0;
      have_prev <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            omega    <= q_data.omega;
            omega_sq <= q_data.omega_sq;
            start_r  <= q_data.sweep_start;
            den_sel  <= 1'b0;
            state    <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          mp    <= mul_p;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          t2lo  <= mp[31:0];
          t2    <= {32'b0, mp};
          mp    <= mul_p;
          state <= S_MUL_C;
        end
        S_MUL_C: begin
          t2    <= {mp, 32'b0} + 96'({t2[63:32], t2lo});
          mp    <= mul_p;
          state <= S_RESUM;
        end
        S_RESUM: begin
          im    <= {mp, 16'b0};
          s_im  <= pc.s1[31];
          re_s  <= c2[31] ? (c0x + t2x) : (c0x - t2x);
          state <= S_REABS;
        end
        S_REABS: begin
          re_m  <= re_s[96] ? 96'(-re_s) : 96'(re_s);
          s_re  <= re_s[96];
          k     <= '0;
          zflag <= (re_s == '0) && (im == '0);
          state <= ((re_s == '0) && (im == '0)) ? S_POST : S_NORM;
        end
        // drop low bits until both parts fit in 30 bits
        S_NORM: begin
          if (or_w[95:38] != '0) begin
            re_m <= re_m >> 8;
            im   <= im >> 8;
            k    <= k + 7'd8;
          end else if (or_w[95:30] != '0) begin
            re_m <= re_m >> 1;
            im   <= im >> 1;
            k    <= k + 7'd1;
          end else begin
            cx    <= $signed({4'b0, re_m[29:0]});
            cy    <= $signed({4'b0, im[29:0]});
            z     <= '0;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          mp    <= mul_p;
          state <= S_SQY;
        end
        S_SQY: begin
          msq   <= mp[59:0];
          mp    <= mul_p;
          state <= S_SQS;
        end
        S_SQS: begin
          mm    <= 61'(msq) + 61'(mp[59:0]);
          e     <= 6'd60;
          state <= S_LNORM;
        end
        // bring the leading one to the top
        S_LNORM: begin
          if (mm[60:53] == '0) begin
            mm <= mm << 8;
            e  <= e - 6'd8;
          end else if (!mm[60]) begin
            mm <= mm << 1;
            e  <= e - 6'd1;
          end else begin
            v     <= mm[60:30];
            frac  <= '0;
            it    <= '0;
            state <= S_ITER;
          end
        end
        // one log2 fraction bit a cycle, with a CORDIC rotation while it < CORDIC_STEPS
        S_ITER: begin
          if (sq[31]) begin
            v    <= sq[31:1];
            frac <= frac | (30'd1 << (5'(LOG_STEPS - 1) - it));
          end else begin
            v <= sq[30:0];
          end
          if (it < 5'(CORDIC_STEPS)) begin
            if (cy > 0) begin
              cx <= cx + dx;
              cy <= cy - dy;
              z  <= z + atan_z;
            end else begin
              cx <= cx - dx;
              cy <= cy + dy;
              z  <= z - atan_z;
            end
          end
          it <= it + 5'd1;
          if (it == 5'(LOG_STEPS - 1)) state <= S_POST;
        end
        S_POST: begin
          if (!den_sel) begin
            ln      <= zflag ? '0 : lval;
            an      <= zflag ? '0 : ang;
            nz      <= zflag;
            den_sel <= 1'b1;
            state   <= S_MUL_A;
          end else begin
            ld    <= zflag ? '0 : lval;
            ad    <= zflag ? '0 : ang;
            dz    <= zflag;
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          gneg  <= ln < ld;
          diff  <= (ln < ld) ? (ld - ln) : (ln - ld);
          raw   <= rawd_w[24:0];
          state <= S_GMUL;
        end
        // scale the log difference and update the unwrap offset
        S_GMUL: begin
          gp <= 63'(diff) * 63'(GAIN_K);
          if (start_r || !have_prev) begin
            offset <= '0;
          end else if (cand[32] == cand[31]) begin
            offset <= cand[31:0];
          end
          prev_raw  <= raw;
          have_prev <= 1'b1;
          state     <= S_GRND;
        end
        // hold until the result register is free
        S_GRND: begin
          if (res_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.gain_db         <= gain_v;
      result.phase_unwrapped <= phase_v;
      result.status          <= status_v;
    end
  end

  // log mantissa stays normalized through the squaring loop
  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) |-> v[30])
    else $error("log mantissa lost its leading one");

  // both parts fit in 30 bits once squaring starts
  a_fit30: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQX) |-> ((re_m[95:30] == '0) && (im[79:30] == '0)))
    else $error("normalization left wide operands");

  // a new result only follows the final rounding step
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_GRND))
    else $error("result raised outside rounding step");

  // the unwrap state is marked after the first point
  a_prev: assert property (@(posedge clk) disable iff (rst)
    (state == S_GMUL) |=> have_prev)
    else $error("unwrap history not recorded");

endmodule
